FILE: hw/rtl/ffe_pkg.sv
// shared types and constants of the flow feature extractor
package ffe_pkg;

  localparam int FLOW_ENTRIES  = 1024;
  localparam int IDX_W         = $clog2(FLOW_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int FRACTION_BITS = 16;

  // in tdata: protocol, src_addr, dst_addr, src_port, dst_port, total_length, now_ns
  localparam int IN_W  = 168;
  // out tdata: packet_total .. dev_direction, padded to whole bytes
  localparam int OUT_W = 440;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_TRACKED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // flow entry record held in the table memory
  localparam int REC_W = 64 + 40 + 32 + 48 + 6 * 64;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_READ, S_READ_WAIT, S_UPDATE,
    S_DIV1, S_DIV1_WAIT, S_DEV, S_DIV2, S_DIV2_WAIT, S_WRITE, S_OUT
  } ffe_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input item
    logic scan_rd;     // read entry at scan index
    logic scan_chk;    // compare entry read last
    logic scan_clr;    // reset scan results
    logic rd_hit;      // read chosen entry
    logic update;      // count, interval, sums
    logic div1_start;  // divide the three sums
    logic dev;         // deviation sums
    logic div2_start;  // divide the three deviation sums
    logic wr;          // write entry back
    logic claim;       // mark chosen entry used
    logic res_ignore;  // result: ignored
    logic res_full;    // result: table full
  } ffe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic track;       // packet is tracked
    logic scan_last;   // scan index past last entry
    logic hit;         // key matched
    logic free;        // free entry seen
    logic div_done;    // divider finished
  } ffe_sts_t;

endpackage

FILE: hw/rtl/ffe_ram.sv
// generic single port ram with registered read
module ffe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, old data returned on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/ffe_div.sv
// three lane restoring divider of 64-bit sums by a 32-bit count
module ffe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num0,
  input  logic [63:0] num1,
  input  logic [63:0] num2,
  input  logic [31:0] den,
  output logic [63:0] quo0,
  output logic [63:0] quo1,
  output logic [63:0] quo2,
  output logic        done
);
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem0, rem1, rem2;
  logic [32:0] t0, t1, t2;

  // shift in one numerator bit per lane
  always_comb begin
    t0 = {rem0[31:0], quo0[63]};
    t1 = {rem1[31:0], quo1[63]};
    t2 = {rem2[31:0], quo2[63]};
  end

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        quo0 <= num0;
        quo1 <= num1;
        quo2 <= num2;
        rem0 <= '0;
        rem1 <= '0;
        rem2 <= '0;
      end else if (busy) begin
        if (t0 >= {1'b0, den}) begin
          rem0 <= t0 - {1'b0, den};
          quo0 <= {quo0[62:0], 1'b1};
        end else begin
          rem0 <= t0;
          quo0 <= {quo0[62:0], 1'b0};
        end
        if (t1 >= {1'b0, den}) begin
          rem1 <= t1 - {1'b0, den};
          quo1 <= {quo1[62:0], 1'b1};
        end else begin
          rem1 <= t1;
          quo1 <= {quo1[62:0], 1'b0};
        end
        if (t2 >= {1'b0, den}) begin
          rem2 <= t2 - {1'b0, den};
          quo2 <= {quo2[62:0], 1'b1};
        end else begin
          rem2 <= t2;
          quo2 <= {quo2[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/ffe_datapath.sv
// flow table, arithmetic and result register
module ffe_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ffe_pkg::ffe_cmd_t   cmd,
  output ffe_pkg::ffe_sts_t   sts,
  input  logic [ffe_pkg::IN_W-1:0]  in_data,
  input  logic                in_ipv4,
  output logic [ffe_pkg::OUT_W-1:0] res_data,
  output logic [1:0]          res_status
);
  import ffe_pkg::*;

  // captured item
  logic [7:0]  proto;
  logic [31:0] saddr, daddr;
  logic [15:0] sport, dport, len;
  logic [47:0] now;
  logic        ipv4;

  // scan state
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] chk_idx, hit_idx, free_idx;
  logic             hit, free;
  // entries are claimed in index order and never released, so the used ones
  // are exactly those below the fill count
  logic [CNT_W-1:0] fill;
  logic             is_new;

  // working entry
  logic [31:0] cnt;
  logic [63:0] s_len, s_int, s_dir, d_len, d_int, d_dir;
  logic [63:0] len_fx, int_fx, m_len, m_int, m_dir;

  // ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [REC_W-1:0] ram_wdata, ram_rdata;

  logic [63:0] r_kaddr;
  logic [39:0] r_kpp;
  logic [31:0] r_cnt;
  logic [47:0] r_last;
  logic [63:0] r_sl, r_si, r_sd, r_dl, r_di, r_dd;

  logic        div_start;
  logic        div_done;
  logic [63:0] dn0, dn1, dn2, q0, q1, q2;

  logic [63:0] kaddr;
  logic [39:0] kpp;
  logic [IDX_W-1:0] ent;

  assign kaddr = {saddr, daddr};
  assign kpp   = {proto, sport, dport};
  assign ent   = hit ? hit_idx : free_idx;
  assign {r_kaddr, r_kpp, r_cnt, r_last, r_sl, r_si, r_sd, r_dl, r_di, r_dd} = ram_rdata;

  // table memory
  ffe_ram #(.WIDTH(REC_W), .DEPTH(FLOW_ENTRIES)) u_tab (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign ram_we    = cmd.wr;
  assign ram_addr  = cmd.scan_rd ? scan_idx[IDX_W-1:0] : ent;
  assign ram_wdata = {kaddr, kpp, cnt, now, s_len, s_int, s_dir, d_len, d_int, d_dir};

  // status
  always_comb begin
    sts.track     = ipv4 && (proto == PROTO_TCP || proto == PROTO_UDP);
    sts.scan_last = (scan_idx == CNT_W'(FLOW_ENTRIES));
    sts.hit       = hit;
    sts.free      = free;
    sts.div_done  = div_done;
  end

  // saturating add
  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] adiff(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // shared divider
  assign div_start = cmd.div1_start | cmd.div2_start;
  assign dn0 = cmd.div1_start ? s_len : d_len;
  assign dn1 = cmd.div1_start ? s_int : d_int;
  assign dn2 = cmd.div1_start ? s_dir : d_dir;

  ffe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num0(dn0), .num1(dn1), .num2(dn2),
    .den(cnt), .quo0(q0), .quo1(q1), .quo2(q2), .done(div_done)
  );

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.claim && is_new) begin
      fill <= fill + CNT_W'(1);
    end
  end

  // scan and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      hit      <= 1'b0;
      free     <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        hit      <= 1'b0;
        free     <= 1'b0;
      end
      if (cmd.scan_rd) begin
        chk_idx  <= scan_idx[IDX_W-1:0];
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (cmd.scan_chk) begin
        if ({1'b0, chk_idx} < fill) begin
          if (!hit && r_kaddr == kaddr && r_kpp == kpp) begin
            hit     <= 1'b1;
            hit_idx <= chk_idx;
          end
        end else if (!free) begin
          free     <= 1'b1;
          free_idx <= chk_idx;
        end
      end
    end
  end

  // item and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {now, len, dport, sport, daddr, saddr, proto} <= in_data;
      ipv4 <= in_ipv4;
    end
    if (cmd.rd_hit) begin
      is_new <= !hit;
    end
    if (cmd.update) begin
      logic [31:0] c0;
      logic [47:0] l0;
      logic [47:0] iv;
      logic [63:0] lf, ifx;
      c0 = is_new ? 32'd0 : r_cnt;
      l0 = is_new ? now : r_last;
      iv = (l0 != 48'd0 && now >= l0) ? now - l0 : 48'd0;
      lf  = {32'd0, len, 16'd0};
      ifx = {iv, 16'd0};
      cnt    <= (c0 == '1) ? c0 : c0 + 32'd1;
      len_fx <= lf;
      int_fx <= ifx;
      s_len  <= sadd(is_new ? 64'd0 : r_sl, lf);
      s_int  <= sadd(is_new ? 64'd0 : r_si, ifx);
      s_dir  <= sadd(is_new ? 64'd0 : r_sd, 64'h10000);
      d_len  <= is_new ? 64'd0 : r_dl;
      d_int  <= is_new ? 64'd0 : r_di;
      d_dir  <= is_new ? 64'd0 : r_dd;
    end
    if (cmd.dev) begin
      m_len <= q0;
      m_int <= q1;
      m_dir <= q2;
      d_len <= sadd(d_len, adiff(len_fx, q0));
      d_int <= sadd(d_int, adiff(int_fx, q1));
      d_dir <= sadd(d_dir, adiff(64'h10000, q2));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_ignore || cmd.res_full) begin
      res_status <= cmd.res_full ? ST_FULL : ST_IGNORED;
      res_data   <= '0;
    end else if (cmd.wr) begin
      res_status <= ST_TRACKED;
      res_data   <= {5'd0, q2[16:0], q1, q0, m_dir[16:0], m_int, m_len, 17'h10000,
                     int_fx, len_fx[31:0], cnt};
    end
  end
endmodule

FILE: hw/rtl/ffe_ctrl.sv
// controller state machine
module ffe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_fire,
  output logic              in_ready,
  output logic              out_valid,
  output ffe_pkg::ffe_cmd_t cmd,
  input  ffe_pkg::ffe_sts_t sts
);
  import ffe_pkg::*;

  ffe_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.track) begin
          cmd.res_ignore = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        cmd.scan_rd = !sts.scan_last;
        if (sts.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.hit && !sts.free) begin
          cmd.res_full = 1'b1;
          state_next   = S_OUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_hit = 1'b1;
        state_next = S_READ_WAIT;
      end
      S_READ_WAIT: state_next = S_UPDATE;
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.div1_start = 1'b1;
        state_next     = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: if (sts.div_done) state_next = S_DEV;
      S_DEV: begin
        cmd.dev    = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2_start = 1'b1;
        state_next     = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: if (sts.div_done) state_next = S_WRITE;
      S_WRITE: begin
        cmd.wr     = 1'b1;
        cmd.claim  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/flow_feature_extractor.sv
// top level of the flow feature extractor
// an ignored item goes straight to the output; a tracked item or a full table waits for a
//   search of the whole table, one entry read per cycle, and a tracked item then for two
//   divider passes
// throughput: one item at a time, the next accepted only after the output is taken
// reset: rst synchronous active high clears the state machine and the table fill count
module flow_feature_extractor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // protocol, src_addr, dst_addr, src_port, dst_port, total_length, now_ns
  input  logic [167:0] s_axis_tdata,
  // is_ipv4
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // packet_total, length_fx, interval_fx, direction_fx, mean_length, mean_interval,
  // mean_direction, dev_length, dev_interval, dev_direction, zero pad
  output logic [439:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);
  import ffe_pkg::*;

  ffe_cmd_t cmd, cmd_c;
  ffe_sts_t sts;
  logic     chk;

  // controller
  ffe_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
    .cmd(cmd_c), .sts(sts)
  );

  // compare runs in the cycle after each table read
  always_ff @(posedge clk) begin
    if (rst) chk <= 1'b0;
    else     chk <= cmd_c.scan_rd;
  end

  always_comb begin
    cmd          = cmd_c;
    cmd.scan_chk = chk;
  end

  // datapath
  ffe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_data(s_axis_tdata), .in_ipv4(s_axis_tuser),
    .res_data(m_axis_tdata), .res_status(m_axis_tuser)
  );

`ifndef SYNTH
  // status is one of the defined codes while offered
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_IGNORED || m_axis_tuser == ST_TRACKED ||
                       m_axis_tuser == ST_FULL)) else $error("bad status");
  // input and output never both open
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  // a write is never in the same cycle as a scan read
  a_wr: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.scan_rd)) else $error("write during scan");
`endif
endmodule
